>>> sv/sap_pkg.sv
package sap_pkg;

  // Event codes carried on the func field
  typedef enum logic [1:0] {
    FUNC_CHECK        = 2'd0,
    FUNC_SENT         = 2'd1,
    FUNC_SET_WINDOW   = 2'd2,
    FUNC_RESET_WINDOW = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [1:0] REG_SEND_INTERVAL  = 2'd0;
  localparam logic [1:0] REG_INITIAL_WINDOW = 2'd1;
  localparam logic [1:0] REG_MAX_LEAD       = 2'd2;
  localparam logic [1:0] REG_RATE           = 2'd3;

  // Fixed constants of the pacing scheme
  localparam logic [15:0] DISABLED_INTERVAL_MS = 16'd200;
  localparam logic [16:0] SEND_AHEAD_SPAN_MS   = 17'd1000;
  localparam logic [9:0]  MS_PER_SECOND        = 10'd1000;
  localparam logic [2:0]  WINDOW_PACKETS       = 3'd5;
  localparam logic [15:0] RATE_ONE_Q8          = 16'd256;
  localparam logic [31:0] WINDOW_UNLIMITED     = 32'hFFFF_FFFF;

  // Reset values of the configuration
  localparam logic [15:0] RESET_INTERVAL_MS = 16'd50;
  localparam logic [25:0] RESET_MAX_LEAD_MS = 26'd25000;
  localparam logic [15:0] RESET_GROWTH_Q8   = 16'd256;

  // Decoded configuration handed to the decision logic
  typedef struct packed {
    logic        enabled;
    logic [15:0] interval_ms;
    logic [25:0] max_lead_ms;
    logic [15:0] growth_q8;
  } pace_cfg_t;

endpackage

>>> sv/sap_decide.sv
module sap_decide #(
  parameter int TIME_BITS = 48
) (
  input  sap_pkg::pace_cfg_t    cfg,
  input  logic [1:0]            func,
  input  logic [TIME_BITS-1:0]  due_ms,
  input  logic [TIME_BITS-1:0]  now_ms,
  input  logic [15:0]           pkt_bytes,
  input  logic [31:0]           win_bytes,
  input  logic [31:0]           client_window,
  input  logic [31:0]           bytes_since_report,
  input  logic [TIME_BITS-1:0]  bucket_start,
  input  logic [TIME_BITS-1:0]  prior_bucket_start,
  input  logic [TIME_BITS-1:0]  lead_now,
  input  logic [TIME_BITS-1:0]  lead_before,
  output logic [31:0]           client_window_next,
  output logic [31:0]           bytes_since_report_next,
  output logic [TIME_BITS-1:0]  bucket_start_next,
  output logic [TIME_BITS-1:0]  prior_bucket_start_next,
  output logic [TIME_BITS-1:0]  lead_now_next,
  output logic [TIME_BITS-1:0]  lead_before_next,
  output logic                  send_now,
  output logic [TIME_BITS-1:0]  send_time_ms
);

  localparam int TB = TIME_BITS;

  logic [TB-1:0]        ivl_t;
  logic signed [TB:0]   ivl_s;
  logic signed [TB:0]   span_s;
  logic signed [TB:0]   max_lead_s;
  logic signed [TB:0]   since_bucket;
  logic                 roll;
  logic [TB-1:0]        bucket_roll;
  logic [TB-1:0]        prior_roll;
  logic [TB-1:0]        lead_before_v;
  logic signed [TB:0]   ahead;
  logic [TB-1:0]        ahead_u;
  logic                 due_soon;
  logic [31:0]          window_free;
  logic [18:0]          pkt_x5;
  logic                 window_low;
  logic                 lead_big;
  logic                 shrink;
  logic [TB-1:0]        d;
  logic                 d_neg;
  logic [TB-1:0]        d_mag;
  logic [TB+15:0]       prod;
  logic [TB+7:0]        q;
  logic [TB-1:0]        a;
  logic                 over;
  logic [TB-1:0]        clamped;

  assign ivl_t      = TB'(cfg.interval_ms);
  assign ivl_s      = $signed({1'b0, ivl_t});
  assign span_s     = $signed((TB+1)'(17'(cfg.interval_ms) + sap_pkg::SEND_AHEAD_SPAN_MS));
  assign max_lead_s = $signed((TB+1)'(cfg.max_lead_ms));

  // Bucket roll-over
  assign since_bucket  = $signed({1'b0, now_ms}) - $signed({1'b0, bucket_start});
  assign roll          = since_bucket > ivl_s;
  assign bucket_roll   = roll ? now_ms : bucket_start;
  assign prior_roll    = !roll ? prior_bucket_start :
                         (bucket_start == '0) ? (now_ms - ivl_t) : bucket_start;
  assign lead_before_v = roll ? lead_now : lead_before;

  // Lead of the packet over real time
  assign ahead    = $signed({1'b0, due_ms}) - $signed({1'b0, now_ms});
  assign ahead_u  = ahead[TB-1:0];
  assign due_soon = (ahead <= ivl_s) || (cfg.enabled && (ahead <= span_s));

  // Free client window against five packets
  assign window_free = client_window - bytes_since_report;
  assign pkt_x5      = 19'(pkt_bytes) * 19'(sap_pkg::WINDOW_PACKETS);
  assign window_low  = (client_window != sap_pkg::WINDOW_UNLIMITED) &&
                       ({13'b0, pkt_x5} > window_free);
  assign lead_big    = ahead > max_lead_s;
  assign shrink      = ahead_u < lead_before_v;

  // Rate limit: lead growth against elapsed time times growth factor
  assign d     = now_ms - prior_roll;
  assign d_neg = d[TB-1];
  assign d_mag = d_neg ? (TB'(0) - d) : d;
  assign prod  = (TB+16)'(d_mag) * (TB+16)'(cfg.growth_q8);
  assign q     = prod[TB+15:8];
  assign a     = ahead_u - lead_before_v;
  assign over  = d_neg ? ((a != '0) || (cfg.growth_q8 != '0))
                       : ({8'b0, a, 8'b0} > prod);

  // Clamp the lead to what the rate allows, saturating at zero backwards
  always_comb begin
    if (!d_neg) begin
      clamped = lead_before_v + q[TB-1:0];
    end else if ({8'b0, lead_before_v} > q) begin
      clamped = lead_before_v - q[TB-1:0];
    end else begin
      clamped = '0;
    end
  end

  // Apply the event
  always_comb begin
    client_window_next      = client_window;
    bytes_since_report_next = bytes_since_report;
    bucket_start_next       = bucket_start;
    prior_bucket_start_next = prior_bucket_start;
    lead_now_next           = lead_now;
    lead_before_next        = lead_before;
    send_now                = 1'b1;
    send_time_ms            = '0;
    unique case (sap_pkg::func_t'(func))
      sap_pkg::FUNC_CHECK: begin
        bucket_start_next       = bucket_roll;
        prior_bucket_start_next = prior_roll;
        lead_before_next        = lead_before_v;
        if (due_soon) begin
          send_now = 1'b1;
        end else if (!cfg.enabled || (client_window == '0)) begin
          send_now     = 1'b0;
          send_time_ms = due_ms;
        end else if (window_low) begin
          send_now     = 1'b0;
          send_time_ms = now_ms + TB'(19'(cfg.interval_ms) * 19'(sap_pkg::WINDOW_PACKETS));
        end else if (lead_big) begin
          send_now     = 1'b0;
          send_time_ms = due_ms - TB'(cfg.max_lead_ms) + ivl_t;
        end else begin
          lead_now_next = ahead_u;
          if (!shrink && over) begin
            lead_now_next = clamped;
            send_now      = 1'b0;
            send_time_ms  = now_ms + ivl_t;
          end
        end
      end
      sap_pkg::FUNC_SENT: begin
        bytes_since_report_next = bytes_since_report + 32'(pkt_bytes);
      end
      sap_pkg::FUNC_SET_WINDOW: begin
        client_window_next      = win_bytes;
        bytes_since_report_next = '0;
      end
      sap_pkg::FUNC_RESET_WINDOW: begin
        bucket_start_next = '0;
        lead_now_next     = '0;
        lead_before_next  = '0;
      end
    endcase
  end

endmodule

>>> sv/send_ahead_pacing_window.sv
// Channel   Handshake              Payload
// config    cfg_write (no wait)    cfg_index, cfg_data
// input     in_valid / in_ready    func, due_time_ms, now_ms, packet_bytes, window_bytes
// output    out_valid / out_ready  send_now, send_time_ms
//
// One beat per cycle is accepted while in_ready is high. A check beat is held in the input
// register and its result is then shown on the result port from the result register;
// other beats yield none. The decision for one beat is a single pass through the input
// register, the decision logic and the result register.
// A stalled result holds the input register only when it carries a check beat.
// Reset (rst, synchronous) empties both registers and returns the pacing state and the
// config to their reset values.
module send_ahead_pacing_window #(
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [TIME_BITS-1:0] due_time_ms,
  input  logic [TIME_BITS-1:0] now_ms,
  input  logic [15:0]          packet_bytes,
  input  logic [31:0]          window_bytes,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 send_now,
  output logic [TIME_BITS-1:0] send_time_ms
);

  sap_pkg::pace_cfg_t    cfg;

  logic                  s_valid;
  logic [1:0]            s_func;
  logic [TIME_BITS-1:0]  s_due;
  logic [TIME_BITS-1:0]  s_now;
  logic [15:0]           s_pkt;
  logic [31:0]           s_window;
  logic                  s_go;
  logic                  out_free;

  logic [31:0]           client_window;
  logic [31:0]           bytes_since_report;
  logic [TIME_BITS-1:0]  bucket_start;
  logic [TIME_BITS-1:0]  prior_bucket_start;
  logic [TIME_BITS-1:0]  lead_now;
  logic [TIME_BITS-1:0]  lead_before;
  logic [31:0]           client_window_next;
  logic [31:0]           bytes_since_report_next;
  logic [TIME_BITS-1:0]  bucket_start_next;
  logic [TIME_BITS-1:0]  prior_bucket_start_next;
  logic [TIME_BITS-1:0]  lead_now_next;
  logic [TIME_BITS-1:0]  lead_before_next;
  logic                  send_now_next;
  logic [TIME_BITS-1:0]  send_time_next;

  // Hand-off between input register and result register
  assign out_free = !out_valid || out_ready;
  assign s_go     = s_valid && ((s_func != sap_pkg::FUNC_CHECK) || out_free);
  assign in_ready = !s_valid || s_go;

  // Decode configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled     <= 1'b1;
      cfg.interval_ms <= sap_pkg::RESET_INTERVAL_MS;
      cfg.max_lead_ms <= sap_pkg::RESET_MAX_LEAD_MS;
      cfg.growth_q8   <= sap_pkg::RESET_GROWTH_Q8;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sap_pkg::REG_SEND_INTERVAL: begin
          cfg.enabled     <= cfg_data[15:0] != '0;
          cfg.interval_ms <= (cfg_data[15:0] == '0) ? sap_pkg::DISABLED_INTERVAL_MS
                                                    : cfg_data[15:0];
        end
        sap_pkg::REG_MAX_LEAD: begin
          cfg.max_lead_ms <= 26'(cfg_data[15:0]) * 26'(sap_pkg::MS_PER_SECOND);
        end
        sap_pkg::REG_RATE: begin
          cfg.growth_q8 <= (cfg_data[15:0] < sap_pkg::RATE_ONE_Q8) ? '0
                           : cfg_data[15:0] - sap_pkg::RATE_ONE_Q8;
        end
        sap_pkg::REG_INITIAL_WINDOW: begin
          // loads the client window below
        end
      endcase
    end
  end

  // Input register: take a beat whenever the slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_func   <= func;
      s_due    <= due_time_ms;
      s_now    <= now_ms;
      s_pkt    <= packet_bytes;
      s_window <= window_bytes;
    end
  end

  sap_decide #(
    .TIME_BITS (TIME_BITS)
  ) u_decide (
    .cfg                     (cfg),
    .func                    (s_func),
    .due_ms                  (s_due),
    .now_ms                  (s_now),
    .pkt_bytes               (s_pkt),
    .win_bytes               (s_window),
    .client_window           (client_window),
    .bytes_since_report      (bytes_since_report),
    .bucket_start            (bucket_start),
    .prior_bucket_start      (prior_bucket_start),
    .lead_now                (lead_now),
    .lead_before             (lead_before),
    .client_window_next      (client_window_next),
    .bytes_since_report_next (bytes_since_report_next),
    .bucket_start_next       (bucket_start_next),
    .prior_bucket_start_next (prior_bucket_start_next),
    .lead_now_next           (lead_now_next),
    .lead_before_next        (lead_before_next),
    .send_now                (send_now_next),
    .send_time_ms            (send_time_next)
  );

  // Pacing state: advance on each beat leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      client_window      <= sap_pkg::WINDOW_UNLIMITED;
      bytes_since_report <= '0;
      bucket_start       <= '0;
      prior_bucket_start <= '0;
      lead_now           <= '0;
      lead_before        <= '0;
    end else begin
      if (s_go) begin
        client_window      <= client_window_next;
        bytes_since_report <= bytes_since_report_next;
        bucket_start       <= bucket_start_next;
        prior_bucket_start <= prior_bucket_start_next;
        lead_now           <= lead_now_next;
        lead_before        <= lead_before_next;
      end
      if (cfg_write && (cfg_index == sap_pkg::REG_INITIAL_WINDOW)) begin
        client_window      <= cfg_data;
        bytes_since_report <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s_go && (s_func == sap_pkg::FUNC_CHECK);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s_go) begin
      send_now     <= send_now_next;
      send_time_ms <= send_time_next;
    end
  end

endmodule

>>> sv/sap_checker.sv
module sap_checker #(
  parameter int TIME_BITS = 48
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 send_now,
  input logic [TIME_BITS-1:0] send_time_ms
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(send_now) && $stable(send_time_ms))
    else $error("result beat changed while stalled");

  // An immediate send carries no retry time
  a_send_now_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_now |-> send_time_ms == '0)
    else $error("send_now result with non-zero retry time");

  // Come out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("block not empty after reset");

  // With no result waiting the input side never stalls
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind send_ahead_pacing_window sap_checker #(.TIME_BITS(TIME_BITS)) u_sap_checker (.*);
